// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication: antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/p2pmr_pkg.sv =====
`default_nettype none

package p2pmr_pkg;

    // Storage sizing
    localparam int HOLD_DEPTH_DEF = 64;
    localparam int MAX_HELD       = 36;   // longest held window (offsets 40..75)

    // Frame offsets, tracked in a narrow counter that saturates past all windows
    localparam int             POS_W      = 7;
    localparam logic [POS_W-1:0] POS_SAT    = 7'd76;
    localparam logic [POS_W-1:0] OFF_RX_DST = 7'd0;
    localparam logic [POS_W-1:0] OFF_TX_SRC = 7'd6;
    localparam logic [POS_W-1:0] OFF_ETYPE  = 7'd12;
    localparam logic [POS_W-1:0] OFF_TX_ARP = 7'd22;
    localparam logic [POS_W-1:0] OFF_RX_ARP = 7'd32;
    localparam logic [POS_W-1:0] OFF_CSUM   = 7'd40;
    localparam logic [POS_W-1:0] OFF_DHCP   = 7'd70;
    localparam logic [POS_W-1:0] MAC_LAST   = 7'd5;   // last byte index of an address

    // Length thresholds
    localparam logic [10:0] LEN_MIN  = 11'd14;
    localparam logic [10:0] LEN_ARP  = 11'd42;
    localparam logic [10:0] LEN_DHCP = 11'd300;

    // EtherType for ARP
    localparam logic [7:0] ETYPE_HI = 8'h08;
    localparam logic [7:0] ETYPE_LO = 8'h06;

    localparam logic [1:0] IFACE_P2P = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRIMARY_MAC   = 2'd0;
    localparam logic [1:0] CFG_SECONDARY_MAC = 2'd1;
    localparam logic [1:0] CFG_SEC_ACTIVE    = 2'd2;

    typedef enum logic [1:0] {
        WIN_ADDR,
        WIN_ARP,
        WIN_DHCP
    } win_kind_t;

    // Byte k of a MAC address, byte 0 in the top bits
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/p2p_frame_mac_rewriter.sv =====
// A byte in no held window goes via the hold memory, read register and output register. Held
// windows (6 or 36 bytes) are released at their last byte or the frame's end, then drain
// one byte per cycle while m_ is not stalled, from the hold memory (one write port, one
// read port). Throughput: one byte per cycle within a frame while the memory has room; a
// frame's first byte waits until the previous frame has fully left the hold memory and its
// read stage. Reset: aresetn synchronous, active low; clears control state, not memory.
`default_nettype none
`include "assert_macros.svh"

module p2p_frame_mac_rewriter
    import p2pmr_pkg::*;
#(
    parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [47:0] cfg_wdata,

    // Frame bytes in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [10:0] frame_len, [18:11] data_byte, [23:19] zero
    input  wire logic [2:0]  s_tuser,   // [0] direction, [2:1] iface_id
    input  wire logic        s_tlast,   // end_of_frame

    // Frame bytes out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // out_last
);

    localparam int PTR_W = $clog2(HOLD_DEPTH);
    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [47:0] primary_mac_reg;
    logic [47:0] secondary_mac_reg;
    logic        sec_active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primary_mac_reg   <= '0;
            secondary_mac_reg <= '0;
            sec_active_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_PRIMARY_MAC:   primary_mac_reg   <= cfg_wdata;
                CFG_SECONDARY_MAC: secondary_mac_reg <= cfg_wdata;
                CFG_SEC_ACTIVE:    sec_active_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input side: frame mode, position, window tracking
    // ---------------------------------------------------------------
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rx_reg, rx_next;
    logic             en_reg, en_next;
    logic             arplen_reg, arplen_next;
    logic             dhcp_reg, dhcp_next;
    logic             arp_reg, arp_next;       // EtherType confirmed ARP
    logic             b12_reg, b12_next;       // byte 12 was 0x08
    logic [47:0]      win_reg, win_next;       // last six bytes seen
    logic             swap_addr_reg, swap_addr_next;
    logic             swap_arp_reg, swap_arp_next;
    logic             swap_dhcp_reg, swap_dhcp_next;

    // FIFO control
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;       // entries written, not yet read
    logic [CNT_W-1:0] held_reg, held_next;     // newest entries not yet released
    logic             rdv_reg, rdv_next;       // read stage holds a byte

    logic             in_xfer;
    logic             first;
    logic [7:0]       in_byte;
    logic [10:0]      in_len;
    logic             cur_rx, cur_en, cur_arplen, cur_dhcp;
    logic [POS_W-1:0] p;
    logic             arp_now;
    logic             held;
    logic             at_end;
    win_kind_t        kind;
    logic [47:0]      match_mac;
    logic [47:0]      window;
    logic             release_now;
    logic             rd_en;
    logic             adv;

    assign in_byte = s_tdata[18:11];
    assign in_len  = s_tdata[10:0];
    assign first   = !in_frame_reg;

    // A new frame starts only once the previous one has fully drained.
    assign s_tready = (occ_reg < CNT_W'(HOLD_DEPTH)) &&
                      (in_frame_reg || (occ_reg == '0 && !rdv_reg));
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        cur_rx     = first ? s_tuser[0] : rx_reg;
        cur_en     = first ? (sec_active_reg && s_tuser[2:1] == IFACE_P2P && in_len >= LEN_MIN)
                           : en_reg;
        cur_arplen = first ? (in_len >= LEN_ARP) : arplen_reg;
        cur_dhcp   = first ? (in_len > LEN_DHCP) : dhcp_reg;
        p          = first ? '0 : pos_reg;
        arp_now    = (first ? 1'b0 : arp_reg) ||
                     (cur_en && cur_arplen && p == OFF_ETYPE + 7'd1 && b12_reg &&
                      in_byte == ETYPE_LO);

        // Window selection, same priority as the address rules
        held   = 1'b0;
        at_end = 1'b0;
        kind   = WIN_ADDR;
        if (cur_en) begin
            if (cur_rx && p <= OFF_RX_DST + MAC_LAST) begin
                held   = 1'b1;
                at_end = (p == OFF_RX_DST + MAC_LAST);
            end else if (!cur_rx && p >= OFF_TX_SRC && p <= OFF_TX_SRC + MAC_LAST) begin
                held   = 1'b1;
                at_end = (p == OFF_TX_SRC + MAC_LAST);
            end else if (arp_now && !cur_rx && p >= OFF_TX_ARP &&
                         p <= OFF_TX_ARP + MAC_LAST) begin
                held   = 1'b1;
                kind   = WIN_ARP;
                at_end = (p == OFF_TX_ARP + MAC_LAST);
            end else if (arp_now && cur_rx && p >= OFF_RX_ARP &&
                         p <= OFF_RX_ARP + MAC_LAST) begin
                held   = 1'b1;
                kind   = WIN_ARP;
                at_end = (p == OFF_RX_ARP + MAC_LAST);
            end else if (cur_dhcp && p >= OFF_CSUM && p <= OFF_DHCP + MAC_LAST) begin
                held   = 1'b1;
                kind   = WIN_DHCP;
                at_end = (p == OFF_DHCP + MAC_LAST);
            end
        end

        window      = {win_reg[39:0], in_byte};
        match_mac   = cur_rx ? primary_mac_reg : secondary_mac_reg;
        release_now = !held || at_end || s_tlast;

        // Next frame state
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        rx_next        = rx_reg;
        en_next        = en_reg;
        arplen_next    = arplen_reg;
        dhcp_next      = dhcp_reg;
        arp_next       = arp_reg;
        b12_next       = b12_reg;
        win_next       = win_reg;
        swap_addr_next = swap_addr_reg;
        swap_arp_next  = swap_arp_reg;
        swap_dhcp_next = swap_dhcp_reg;
        if (in_xfer) begin
            in_frame_next = !s_tlast;
            pos_next      = s_tlast ? '0 : ((p < POS_SAT) ? p + 7'd1 : POS_SAT);
            rx_next       = cur_rx;
            en_next       = cur_en;
            arplen_next   = cur_arplen;
            dhcp_next     = cur_dhcp;
            arp_next      = arp_now;
            if (p == OFF_ETYPE) begin
                b12_next = (in_byte == ETYPE_HI);
            end
            win_next = window;
            if (first) begin
                swap_addr_next = 1'b0;
                swap_arp_next  = 1'b0;
                swap_dhcp_next = 1'b0;
            end
            // Compare against live registers when the window completes
            if (at_end && window == match_mac) begin
                case (kind)
                    WIN_ADDR: swap_addr_next = 1'b1;
                    WIN_ARP:  swap_arp_next  = 1'b1;
                    WIN_DHCP: swap_dhcp_next = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            rx_reg        <= 1'b0;
            en_reg        <= 1'b0;
            arplen_reg    <= 1'b0;
            dhcp_reg      <= 1'b0;
            arp_reg       <= 1'b0;
            b12_reg       <= 1'b0;
            swap_addr_reg <= 1'b0;
            swap_arp_reg  <= 1'b0;
            swap_dhcp_reg <= 1'b0;
        end else begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            rx_reg        <= rx_next;
            en_reg        <= en_next;
            arplen_reg    <= arplen_next;
            dhcp_reg      <= dhcp_next;
            arp_reg       <= arp_next;
            b12_reg       <= b12_next;
            swap_addr_reg <= swap_addr_next;
            swap_arp_reg  <= swap_arp_next;
            swap_dhcp_reg <= swap_dhcp_next;
        end
    end

    // Window bytes are payload; no reset needed
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    // ---------------------------------------------------------------
    // Hold memory: {last, byte}, one write and one registered read a cycle
    // ---------------------------------------------------------------
    logic [8:0] hold_mem [HOLD_DEPTH];
    logic [8:0] mem_q_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            hold_mem[wptr_reg] <= {s_tlast, in_byte};
        end
        if (rd_en) begin
            mem_q_reg <= hold_mem[rptr_reg];
        end
    end

    // Read stage advances into the output register when that is free or taken
    assign adv   = rdv_reg && (!m_tvalid || m_tready);
    assign rd_en = (occ_reg != held_reg) && (!rdv_reg || adv);

    always_comb begin
        occ_next = occ_reg;
        if (in_xfer && !rd_en) begin
            occ_next = occ_reg + 1'b1;
        end else if (!in_xfer && rd_en) begin
            occ_next = occ_reg - 1'b1;
        end

        held_next = held_reg;
        if (in_xfer) begin
            held_next = release_now ? '0 : held_reg + 1'b1;
        end

        rdv_next = rd_en ? 1'b1 : (adv ? 1'b0 : rdv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            occ_reg  <= '0;
            held_reg <= '0;
            rdv_reg  <= 1'b0;
        end else begin
            if (in_xfer) begin
                wptr_reg <= (wptr_reg == PTR_W'(HOLD_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd_en) begin
                rptr_reg <= (rptr_reg == PTR_W'(HOLD_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            occ_reg  <= occ_next;
            held_reg <= held_next;
            rdv_reg  <= rdv_next;
        end
    end

    // ---------------------------------------------------------------
    // Drain side: rewrite on the way out, by frame offset of the byte
    // ---------------------------------------------------------------
    logic [POS_W-1:0] dpos_reg, dpos_next;
    logic [47:0]      repl_mac;
    logic [7:0]       sub_byte;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;

    always_comb begin
        repl_mac = rx_reg ? secondary_mac_reg : primary_mac_reg;
        sub_byte = mem_q_reg[7:0];
        if (swap_addr_reg && rx_reg && dpos_reg <= OFF_RX_DST + MAC_LAST) begin
            sub_byte = mac_byte(repl_mac, 3'(dpos_reg - OFF_RX_DST));
        end else if (swap_addr_reg && !rx_reg && dpos_reg >= OFF_TX_SRC &&
                     dpos_reg <= OFF_TX_SRC + MAC_LAST) begin
            sub_byte = mac_byte(repl_mac, 3'(dpos_reg - OFF_TX_SRC));
        end else if (swap_arp_reg && !rx_reg && dpos_reg >= OFF_TX_ARP &&
                     dpos_reg <= OFF_TX_ARP + MAC_LAST) begin
            sub_byte = mac_byte(repl_mac, 3'(dpos_reg - OFF_TX_ARP));
        end else if (swap_arp_reg && rx_reg && dpos_reg >= OFF_RX_ARP &&
                     dpos_reg <= OFF_RX_ARP + MAC_LAST) begin
            sub_byte = mac_byte(repl_mac, 3'(dpos_reg - OFF_RX_ARP));
        end else if (swap_dhcp_reg && dpos_reg >= OFF_DHCP &&
                     dpos_reg <= OFF_DHCP + MAC_LAST) begin
            sub_byte = mac_byte(repl_mac, 3'(dpos_reg - OFF_DHCP));
        end else if (swap_dhcp_reg && (dpos_reg == OFF_CSUM || dpos_reg == OFF_CSUM + 7'd1)) begin
            // UDP checksum cleared along with the client address
            sub_byte = 8'h00;
        end

        dpos_next = dpos_reg;
        if (adv) begin
            dpos_next = mem_q_reg[8] ? '0 : ((dpos_reg < POS_SAT) ? dpos_reg + 7'd1 : POS_SAT);
        end

        m_tvalid_next = adv ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpos_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            dpos_reg     <= dpos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= sub_byte;
            m_tlast_reg <= mem_q_reg[8];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_CLK(a_held_in_fifo, held_reg <= occ_reg, "held bytes exceed memory occupancy")
    `ASSERT_CLK(a_held_bound, held_reg <= CNT_W'(MAX_HELD), "held run longer than any window")
    `ASSERT_CLK(a_occ_bound, occ_reg <= CNT_W'(HOLD_DEPTH), "hold memory overflow")
    `ASSERT_IMPL(a_frame_start_empty, in_xfer && !in_frame_reg,
                 occ_reg == '0 && !rdv_reg && held_reg == '0,
                 "frame started before previous frame drained")

endmodule

`default_nettype wire
